// File: rtl/core/bspd_pkg.sv
// Shared types, status codes and register indexes for the byte-stuffed packet deframer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bspd_pkg;

  // Default receive buffer size and the shortest packet that can be judged
  localparam int unsigned BUFFER_BYTES_DEF = 1024;
  localparam int unsigned MIN_PACKET       = 4;

  // Result status codes
  localparam logic [3:0] ST_IGNORED  = 4'd0;
  localparam logic [3:0] ST_NODATA   = 4'd1;
  localparam logic [3:0] ST_DROPPED  = 4'd2;
  localparam logic [3:0] ST_START    = 4'd3;
  localparam logic [3:0] ST_RESTART  = 4'd4;
  localparam logic [3:0] ST_STORED   = 4'd5;
  localparam logic [3:0] ST_ESCPEND  = 4'd6;
  localparam logic [3:0] ST_GOOD     = 4'd7;
  localparam logic [3:0] ST_LINEERR  = 4'd8;
  localparam logic [3:0] ST_OVERLEN  = 4'd9;
  localparam logic [3:0] ST_ESCBAD   = 4'd10;
  localparam logic [3:0] ST_SHORT    = 4'd11;
  localparam logic [3:0] ST_BADSUM   = 4'd12;
  localparam logic [3:0] ST_RELEASED = 4'd13;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CHAR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CHAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CHAR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESCAPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_STOP      = 3'd5;

  // Configuration reset values
  localparam logic [7:0] RST_OPEN_CHAR  = 8'd170;
  localparam logic [7:0] RST_CLOSE_CHAR = 8'd204;
  localparam logic [7:0] RST_ESC_CHAR   = 8'd187;
  localparam logic [7:0] RST_ESC_ESCAPE = 8'd68;
  localparam logic [7:0] RST_ESC_START  = 8'd85;
  localparam logic [7:0] RST_ESC_STOP   = 8'd51;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       rx_full;
    logic [3:0] error_flags;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [10:0] packet_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] open_char;
    logic [7:0] close_char;
    logic [7:0] esc_char;
    logic [7:0] escaped_escape_code;
    logic [7:0] escaped_start_code;
    logic [7:0] escaped_stop_code;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/bspd_cfg.sv
// Configuration register file of the deframer: framing bytes and escape codes.
// Depends on bspd_pkg.
`default_nettype none

module bspd_cfg
  import bspd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPEN_CHAR:  cfg_d.open_char           = cfg_wdata_i;
        CFG_CLOSE_CHAR: cfg_d.close_char          = cfg_wdata_i;
        CFG_ESC_CHAR:   cfg_d.esc_char            = cfg_wdata_i;
        CFG_ESC_ESCAPE: cfg_d.escaped_escape_code = cfg_wdata_i;
        CFG_ESC_START:  cfg_d.escaped_start_code  = cfg_wdata_i;
        CFG_ESC_STOP:   cfg_d.escaped_stop_code   = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_char           <= RST_OPEN_CHAR;
      cfg_q.close_char          <= RST_CLOSE_CHAR;
      cfg_q.esc_char            <= RST_ESC_CHAR;
      cfg_q.escaped_escape_code <= RST_ESC_ESCAPE;
      cfg_q.escaped_start_code  <= RST_ESC_START;
      cfg_q.escaped_stop_code   <= RST_ESC_STOP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/bspd_parse.sv
// Input register, parser state and single-pass decode of one event per cycle while not stalled.
// Depends on bspd_pkg; feeds the result register in bspd_outreg.
`default_nettype none

module bspd_parse
  import bspd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      in_item_i,
  input  cfg_t          cfg_i,
  input  wire logic     res_ready_i,
  output logic          res_valid_o,
  output out_item_t     res_item_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

  // Input stage
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     accept, advance;

  // Parser state
  logic             rx_en_q, rx_en_d;
  logic             in_pkt_q, in_pkt_d;
  logic             esc_q, esc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       last_q, last_d;

  // Decode scratch
  logic       clr, clr_open, store;
  logic [7:0] store_val;
  logic [7:0] sum_red;
  logic [31:0] cnt_ext;
  out_item_t  res;

  assign advance    = s1_valid_q && res_ready_i;
  assign in_stall_o = s1_valid_q && !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold the input stage until the result register can take its result
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
  end

  assign sum_red = sum_q - last_q;
  assign cnt_ext = 32'(cnt_q);

  // Decode one event against the current state
  always_comb begin
    rx_en_d   = rx_en_q;
    in_pkt_d  = in_pkt_q;
    esc_d     = esc_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    last_d    = last_q;
    res       = '0;
    clr       = 1'b0;
    clr_open  = 1'b0;
    store     = 1'b0;
    store_val = s1_item_q.rx_byte;

    if (s1_item_q.operation) begin
      clr        = 1'b1;
      res.status = ST_RELEASED;
    end else if (!rx_en_q) begin
      res.status = ST_IGNORED;
    end else if (|s1_item_q.error_flags) begin
      clr        = 1'b1;
      res.status = ST_LINEERR;
    end else if (!s1_item_q.rx_full) begin
      res.status = ST_NODATA;
    end else if (s1_item_q.rx_byte == cfg_i.open_char) begin
      // An unescaped start byte reopens the packet, pending escape or not
      clr        = 1'b1;
      clr_open   = 1'b1;
      res.status = in_pkt_q ? ST_RESTART : ST_START;
    end else if (cnt_q >= CNT_W'(BUFFER_BYTES)) begin
      clr        = 1'b1;
      res.status = ST_OVERLEN;
    end else if (!in_pkt_q) begin
      res.status = ST_DROPPED;
    end else if (esc_q) begin
      // Second byte of an escape pair: first matching code wins
      esc_d = 1'b0;
      if (s1_item_q.rx_byte == cfg_i.escaped_escape_code) begin
        store     = 1'b1;
        store_val = cfg_i.esc_char;
      end else if (s1_item_q.rx_byte == cfg_i.escaped_start_code) begin
        store     = 1'b1;
        store_val = cfg_i.open_char;
      end else if (s1_item_q.rx_byte == cfg_i.escaped_stop_code) begin
        store     = 1'b1;
        store_val = cfg_i.close_char;
      end else begin
        clr        = 1'b1;
        res.status = ST_ESCBAD;
      end
    end else if (s1_item_q.rx_byte == cfg_i.esc_char) begin
      esc_d      = 1'b1;
      res.status = ST_ESCPEND;
    end else if (s1_item_q.rx_byte == cfg_i.close_char) begin
      // Last stored byte is the checksum over the bytes before it
      if (cnt_q < CNT_W'(MIN_PACKET)) begin
        clr        = 1'b1;
        res.status = ST_SHORT;
      end else if (sum_red == last_q) begin
        sum_d             = sum_red;
        rx_en_d           = 1'b0;
        res.status        = ST_GOOD;
        res.packet_length = cnt_ext[10:0];
      end else begin
        clr        = 1'b1;
        res.status = ST_BADSUM;
      end
    end else begin
      store = 1'b1;
    end

    if (store) begin
      last_d         = store_val;
      sum_d          = sum_q + store_val;
      cnt_d          = cnt_q + CNT_W'(1);
      res.status     = ST_STORED;
      res.data_byte  = store_val;
      res.byte_index = cnt_ext[9:0];
    end

    if (clr) begin
      in_pkt_d = clr_open;
      esc_d    = 1'b0;
      cnt_d    = '0;
      sum_d    = '0;
      last_d   = '0;
      rx_en_d  = 1'b1;
    end
  end

  // Advance state only when the event leaves for the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rx_en_q    <= 1'b1;
      in_pkt_q   <= 1'b0;
      esc_q      <= 1'b0;
      cnt_q      <= '0;
      sum_q      <= '0;
      last_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        rx_en_q  <= rx_en_d;
        in_pkt_q <= in_pkt_d;
        esc_q    <= esc_d;
        cnt_q    <= cnt_d;
        sum_q    <= sum_d;
        last_q   <= last_d;
      end
    end
  end

  assign res_valid_o = s1_valid_q;
  assign res_item_o  = res;

endmodule

`default_nettype wire

// File: rtl/core/bspd_outreg.sv
// Result register of the deframer: holds one result until the consumer takes it.
// Depends on bspd_pkg.
`default_nettype none

module bspd_outreg
  import bspd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  out_item_t res_item_i,
  output logic      res_ready_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      load;

  // Take a new result when empty or when the held one is being transferred
  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/core/byte_stuffed_packet_deframer_unit.sv
// Top level of the byte-stuffed packet deframer with additive 8-bit checksum.
// Depends on bspd_pkg, bspd_cfg, bspd_parse and bspd_outreg.
//
//   Channel   Direction  Handshake                      Payload
//   in        input      in_valid_i / in_stall_o        in_item_i   (in_item_t)
//   out       output     out_valid_o / out_stall_i      out_item_o  (out_item_t)
//   cfg       input      cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// Every transfer in gives exactly one result: the event waits in the input
// register, and its decode is registered into the result register.
// One event per cycle is sustained while out does not stall; the decode is a set of byte compares and an
// 8-bit add and subtract between the input register and the result register.
// Reset (rst_ni low, asynchronous) opens reception with no packet open.
// A stall on out holds the result register, then the input register, then in.
`default_nettype none

module byte_stuffed_packet_deframer_unit
  import bspd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  in_item_t                  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  bspd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bspd_parse #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  bspd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_item_i  (res_item),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // The input side only stalls while a result waits in the result register
  a_stall_needs_full_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

  // Data and index are only carried by stored results
  a_payload_only_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_STORED) |->
      (out_item_o.data_byte == 8'd0 && out_item_o.byte_index == 10'd0))
    else $error("data or index set on a result that is not a stored byte");

  // A good packet is never shorter than the minimum length
  a_good_min_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_GOOD) |->
      (out_item_o.packet_length >= 11'(MIN_PACKET)))
    else $error("good packet shorter than the minimum");

  // Length is only reported with a good packet
  a_length_only_good : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_GOOD) |->
      (out_item_o.packet_length == 11'd0))
    else $error("packet length set on a result that is not good");

endmodule

`default_nettype wire
